// ----- sv/xcr_pkg.sv -----
// XMODEM receiver package: transfer types, phase codes, protocol bytes.
// Used by every module of the xmodem_crc_receiver block.
`timescale 1ns / 1ps
package xcr_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic [7:0]  send_byte;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [6:0]  data_offset;
      logic        commit;
      logic [23:0] commit_address;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] connect_key;
      logic [3:0]  connect_len;
      logic [7:0]  connect_timeout;
      logic [7:0]  start_timeout;
      logic [23:0] write_limit;
      logic        check_mode;
   } cfg_type;

   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type r0;
      rsp_type r1;
   } core_out_type;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [2:0] ST_CONNECT = 3'd0;
   localparam logic [2:0] ST_AWAIT   = 3'd1;
   localparam logic [2:0] ST_RECEIVE = 3'd2;
   localparam logic [2:0] ST_DONE    = 3'd3;
   localparam logic [2:0] ST_FAILED  = 3'd4;
   localparam logic [2:0] ST_TIMEOUT = 3'd5;

   localparam logic [2:0] CSR_KEY       = 3'd0;
   localparam logic [2:0] CSR_LEN       = 3'd1;
   localparam logic [2:0] CSR_CONN_TMO  = 3'd2;
   localparam logic [2:0] CSR_START_TMO = 3'd3;
   localparam logic [2:0] CSR_LIMIT     = 3'd4;
   localparam logic [2:0] CSR_MODE      = 3'd5;

   localparam logic [7:0] BYTE_C   = 8'h43;
   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [2:0]  MAX_ERRORS = 3'd3;
   localparam logic [7:0]  TIMEOUT_RESET = 8'd10;
   localparam logic [3:0]  KEY_LEN_MAX = 4'd8;

   localparam int FIFO_DEPTH = 4;

endpackage

// ----- sv/xmodem_crc_receiver.sv -----
// XMODEM-CRC receiver with connect-key gate; top level.
// Each request is registered, then its results are queued for output.
// Throughput: one request per cycle; requests stall while fewer than two
// result-queue entries are free (a frame abort yields two results).
// Reset: synchronous, active high; registers return to their reset values.
// Depends on xcr_pkg, xcr_core, xcr_fifo.
`timescale 1ns / 1ps
module xmodem_crc_receiver #(
   parameter int FRAME_BYTES  = 128,
   parameter int ADDRESS_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  xcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output xcr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data
);
   import xcr_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         in_valid_ff, in_valid_in;
   req_type      in_item_ff;
   logic         room;
   logic         fire;
   logic         csr_write;
   logic         reload;
   core_out_type core_out;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign reload    = csr_write && (csr_index == CSR_CONN_TMO);
   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY:       cfg_in.connect_key     = csr_data;
            CSR_LEN:       cfg_in.connect_len     = csr_data[3:0];
            CSR_CONN_TMO:  cfg_in.connect_timeout = csr_data[7:0];
            CSR_START_TMO: cfg_in.start_timeout   = csr_data[7:0];
            CSR_LIMIT:     cfg_in.write_limit     = csr_data[23:0];
            CSR_MODE:      cfg_in.check_mode      = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.connect_key     <= 64'd0;
         cfg_ff.connect_len     <= 4'd1;
         cfg_ff.connect_timeout <= TIMEOUT_RESET;
         cfg_ff.start_timeout   <= TIMEOUT_RESET;
         cfg_ff.write_limit     <= 24'd0;
         cfg_ff.check_mode      <= 1'b0;
         in_valid_ff            <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   xcr_core #(
      .FRAME_BYTES  (FRAME_BYTES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .req          (in_item_ff),
      .cfg          (cfg_ff),
      .reload       (reload),
      .reload_value (csr_data[7:0]),
      .core_out     (core_out)
   );

   xcr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (core_out.v0),
      .push1     (core_out.v1),
      .data0     (core_out.r0),
      .data1     (core_out.r1),
      .pop       (rsp_ready),
      .not_empty (rsp_valid),
      .head      (rsp_data),
      .room      (room)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      core_out.v1 |-> (core_out.v0 && !core_out.r0.last && core_out.r0.status == ST_FAILED))
      else $error("abort result without a leading non-final result");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && in_valid_ff) |-> fire)
      else $error("request taken over an unconsumed item");

   assert property (@(posedge clock) disable iff (reset)
      (!fire) |-> (!core_out.v0 && !core_out.v1))
      else $error("result pushed without a consumed item");
`endif

endmodule

// ----- sv/xcr_check.sv -----
// Frame check update for one data byte: CRC-16 poly 0x1021 or byte sum.
// Depends on xcr_pkg.
`timescale 1ns / 1ps
module xcr_check (
   input  logic [15:0] acc,
   input  logic [7:0]  data,
   input  logic        mode,
   output logic [15:0] acc_next
);
   import xcr_pkg::*;

   logic [15:0] crc;

   always_comb begin
      crc = acc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      acc_next = mode ? (acc + {8'h00, data}) : crc;
   end

endmodule

// ----- sv/xcr_fifo.sv -----
// Result queue: up to two pushes and one pop per cycle.
// Depends on xcr_pkg.
`timescale 1ns / 1ps
module xcr_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push0,
   input  logic             push1,
   input  xcr_pkg::rsp_type data0,
   input  xcr_pkg::rsp_type data1,
   input  logic             pop,
   output logic             not_empty,
   output xcr_pkg::rsp_type head,
   output logic             room
);
   import xcr_pkg::*;

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

   rsp_type               mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [PTR_BITS-1:0]   tail_next;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_pop;

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[head_ff];
   assign room      = (count_ff <= CNT_BITS'(FIFO_DEPTH - 2));
   assign do_pop    = pop && not_empty;
   assign tail_next = tail_ff + PTR_BITS'(1);

   always_comb begin
      head_in  = head_ff + PTR_BITS'(do_pop);
      tail_in  = tail_ff + PTR_BITS'(push0) + PTR_BITS'(push1);
      count_in = count_ff + CNT_BITS'(push0) + CNT_BITS'(push1) - CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[tail_ff] <= data0;
      end
      if (push1) begin
         mem_ff[tail_next] <= data1;
      end
   end

endmodule

// ----- sv/xcr_core.sv -----
// Receiver state and per-item decision: key match, start, frame check, commit.
// Depends on xcr_pkg and xcr_check.
`timescale 1ns / 1ps
module xcr_core #(
   parameter int FRAME_BYTES  = 128,
   parameter int ADDRESS_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  xcr_pkg::req_type       req,
   input  xcr_pkg::cfg_type       cfg,
   input  logic                   reload,
   input  logic [7:0]             reload_value,
   output xcr_pkg::core_out_type  core_out
);
   import xcr_pkg::*;

   localparam int POS_BITS = $clog2(FRAME_BYTES + 5);
   localparam logic [POS_BITS-1:0] POS_LEAD    = POS_BITS'(0);
   localparam logic [POS_BITS-1:0] POS_BLOCK   = POS_BITS'(1);
   localparam logic [POS_BITS-1:0] POS_COMPL   = POS_BITS'(2);
   localparam logic [POS_BITS-1:0] POS_DATA    = POS_BITS'(3);
   localparam logic [POS_BITS-1:0] POS_CHK_HI  = POS_BITS'(FRAME_BYTES + 3);

   logic [2:0]              phase_ff, phase_in;
   logic [7:0]              tick_ff, tick_in;
   logic [3:0]              key_matched_ff, key_matched_in;
   logic [7:0]              expected_ff, expected_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [7:0]              got_block_ff, got_block_in;
   logic [7:0]              got_compl_ff, got_compl_in;
   logic [15:0]             check_ff, check_in;
   logic [7:0]              check_high_ff, check_high_in;
   logic [2:0]              errors_ff, errors_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;

   logic [15:0]             check_upd;
   logic [3:0]              len_eff;
   logic [7:0]              want;
   logic [7:0]              tick_dec;
   logic [POS_BITS-1:0]     offset;
   logic [POS_BITS+6:0]     offset_ext;
   logic [32:0]             addr_ext;
   logic [32:0]             limit_ext;
   logic                    frame_ok;
   logic                    limit_ok;
   logic                    abort;
   rsp_type                 r0;

   xcr_check u_check (
      .acc      (check_ff),
      .data     (req.rx_byte),
      .mode     (cfg.check_mode),
      .acc_next (check_upd)
   );

   always_comb begin
      if (cfg.connect_len == 4'd0) begin
         len_eff = 4'd1;
      end else if (cfg.connect_len > KEY_LEN_MAX) begin
         len_eff = KEY_LEN_MAX;
      end else begin
         len_eff = cfg.connect_len;
      end
   end

   assign want       = cfg.connect_key[{key_matched_ff[2:0], 3'b000} +: 8];
   assign tick_dec   = tick_ff - 8'd1;
   assign offset     = pos_ff - POS_DATA;
   assign offset_ext = {7'b0, offset};
   assign addr_ext   = {{(33 - ADDRESS_BITS){1'b0}}, addr_ff};
   assign limit_ext  = {9'b0, cfg.write_limit};
   assign limit_ok   = (cfg.write_limit == 24'd0) || (addr_ext < limit_ext);
   assign frame_ok   = (got_block_ff == expected_ff)
                    && (~got_compl_ff == expected_ff)
                    && (check_high_ff == check_ff[15:8])
                    && (req.rx_byte == check_ff[7:0]);

   always_comb begin
      phase_in       = phase_ff;
      tick_in        = tick_ff;
      key_matched_in = key_matched_ff;
      expected_in    = expected_ff;
      pos_in         = pos_ff;
      got_block_in   = got_block_ff;
      got_compl_in   = got_compl_ff;
      check_in       = check_ff;
      check_high_in  = check_high_ff;
      errors_in      = errors_ff;
      addr_in        = addr_ff;
      abort          = 1'b0;
      r0             = '0;

      if (fire) begin
         unique case (phase_ff)
            ST_CONNECT: begin
               if (req.command == CMD_TICK) begin
                  if (key_matched_ff >= len_eff) begin
                     phase_in = ST_AWAIT;
                     tick_in  = cfg.start_timeout;
                  end else begin
                     tick_in = tick_dec;
                     if (tick_dec == 8'd0) begin
                        phase_in = ST_TIMEOUT;
                     end
                  end
               end else if (key_matched_ff < len_eff) begin
                  key_matched_in = (req.rx_byte == want) ? key_matched_ff + 4'd1 : 4'd0;
               end
            end
            ST_AWAIT: begin
               if (req.command == CMD_TICK) begin
                  r0.send_valid = 1'b1;
                  r0.send_byte  = BYTE_C;
                  tick_in       = tick_dec;
                  if (tick_dec == 8'd0) begin
                     phase_in = ST_TIMEOUT;
                  end
               end else if (req.rx_byte == BYTE_SOH) begin
                  phase_in    = ST_RECEIVE;
                  pos_in      = POS_BLOCK;
                  expected_in = 8'd1;
                  errors_in   = 3'd0;
                  addr_in     = '0;
                  check_in    = 16'd0;
               end
            end
            ST_RECEIVE: begin
               if (req.command == CMD_BYTE) begin
                  priority if (pos_ff == POS_LEAD) begin
                     if (req.rx_byte == BYTE_EOT) begin
                        r0.send_valid = 1'b1;
                        r0.send_byte  = BYTE_ACK;
                        phase_in      = (errors_ff != 3'd0) ? ST_FAILED : ST_DONE;
                     end else begin
                        pos_in = POS_BLOCK;
                     end
                  end else if (pos_ff == POS_BLOCK) begin
                     got_block_in = req.rx_byte;
                     check_in     = 16'd0;
                     pos_in       = POS_COMPL;
                  end else if (pos_ff == POS_COMPL) begin
                     got_compl_in = req.rx_byte;
                     pos_in       = POS_DATA;
                  end else if (pos_ff < POS_CHK_HI) begin
                     r0.data_valid  = 1'b1;
                     r0.data_byte   = req.rx_byte;
                     r0.data_offset = offset_ext[6:0];
                     check_in       = check_upd;
                     pos_in         = pos_ff + POS_BITS'(1);
                  end else if (pos_ff == POS_CHK_HI) begin
                     check_high_in = req.rx_byte;
                     pos_in        = pos_ff + POS_BITS'(1);
                  end else begin
                     pos_in        = POS_LEAD;
                     r0.send_valid = 1'b1;
                     if (frame_ok) begin
                        r0.send_byte = BYTE_ACK;
                        if (limit_ok) begin
                           r0.commit         = 1'b1;
                           r0.commit_address = addr_ext[23:0];
                           addr_in           = addr_ff + ADDRESS_BITS'(FRAME_BYTES);
                        end
                        errors_in   = 3'd0;
                        expected_in = expected_ff + 8'd1;
                     end else begin
                        r0.send_byte = BYTE_NAK;
                        errors_in    = errors_ff + 3'd1;
                        if (errors_in > MAX_ERRORS) begin
                           phase_in = ST_FAILED;
                           abort    = 1'b1;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (reload && phase_ff == ST_CONNECT) begin
         tick_in = reload_value;
      end

      r0.status = phase_in;
      r0.last   = !abort;
   end

   always_comb begin
      core_out.v0 = fire && (r0.send_valid || r0.data_valid || r0.commit
                             || phase_in != phase_ff);
      core_out.v1 = abort;
      core_out.r0 = r0;
      core_out.r1 = '0;
      core_out.r1.send_valid = 1'b1;
      core_out.r1.send_byte  = BYTE_ACK;
      core_out.r1.status     = ST_FAILED;
      core_out.r1.last       = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ST_CONNECT;
         tick_ff        <= TIMEOUT_RESET;
         key_matched_ff <= 4'd0;
         expected_ff    <= 8'd1;
         pos_ff         <= '0;
         check_ff       <= 16'd0;
         errors_ff      <= 3'd0;
         addr_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         tick_ff        <= tick_in;
         key_matched_ff <= key_matched_in;
         expected_ff    <= expected_in;
         pos_ff         <= pos_in;
         check_ff       <= check_in;
         errors_ff      <= errors_in;
         addr_ff        <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      got_block_ff  <= got_block_in;
      got_compl_ff  <= got_compl_in;
      check_high_ff <= check_high_in;
   end

endmodule

// ----- verif/tb_xmodem_crc_receiver.sv -----
// Self-checking testbench for xmodem_crc_receiver: connect key, 'C' polling, and
// XMODEM frames with CRC-16 or byte-sum checks, predicted in-line and compared per field.
// Depends on xcr_pkg and the xmodem_crc_receiver RTL.
`timescale 1ns / 1ps
module tb_xmodem_crc_receiver;
   import xcr_pkg::*;

   localparam int FRAME_BYTES     = 128;
   localparam int ADDRESS_BITS    = 24;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PRESSURE_AT     = 300;
   localparam int PRESSURE_CYCLES = 400;

   typedef enum int {FLAW_NONE, FLAW_BLOCK, FLAW_COMPL, FLAW_CHECK} flaw_type;
   typedef enum int {CLOSE_CLEAN, CLOSE_AFTER_NAK, CLOSE_ABORT} close_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_KEY;
   logic [63:0] csr_data = '0;

   req_type req_backlog[$];
   rsp_type rsp_due[$];
   int      items_queued = 0;
   int      items_taken = 0;
   int      fed_bytes = 0;
   int      fail_count = 0;
   int      cycle_count = 0;
   int      req_gap_pct = 14;
   int      rsp_gap_pct = 79;
   int      hold_off = 0;
   int      results_taken = 0;

   // receiver model state
   cfg_type                 model_cfg;
   logic [2:0]              rx_phase;
   logic [7:0]              ticks_left;
   logic [3:0]              key_hits;
   logic [7:0]              next_block;
   int                      frame_pos;
   logic [7:0]              rcv_block;
   logic [7:0]              rcv_compl;
   logic [15:0]             frame_check;
   logic [7:0]              check_msb;
   logic [2:0]              nak_run;
   logic [ADDRESS_BITS-1:0] load_addr;

   // sender-side frame builder state
   logic [7:0] tx_block = 8'd1;
   int         tx_nak_run = 0;
   logic       tx_mode = 1'b0;

   xmodem_crc_receiver #(
      .FRAME_BYTES(FRAME_BYTES),
      .ADDRESS_BITS(ADDRESS_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] check_next(logic [15:0] acc, logic [7:0] b, logic mode);
      if (mode) return acc + 16'(b);
      acc = acc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (acc[15]) acc = (acc << 1) ^ CRC_POLY;
         else acc = acc << 1;
      end
      return acc;
   endfunction

   task automatic load_csr(input logic [2:0] idx, input logic [63:0] value);
      case (idx)
         CSR_KEY:       model_cfg.connect_key = value;
         CSR_LEN:       model_cfg.connect_len = value[3:0];
         CSR_CONN_TMO: begin
            model_cfg.connect_timeout = value[7:0];
            if (rx_phase == ST_CONNECT) ticks_left = value[7:0];
         end
         CSR_START_TMO: model_cfg.start_timeout = value[7:0];
         CSR_LIMIT:     model_cfg.write_limit = value[23:0];
         CSR_MODE:      model_cfg.check_mode = value[0];
         default: ;
      endcase
   endtask

   task automatic advance_receiver(input req_type r);
      rsp_type    o;
      logic [2:0] prior;
      logic [3:0] len;
      logic [7:0] want;
      logic       good;
      logic       aborted;
      o = '0;
      prior = rx_phase;
      aborted = 1'b0;
      case (rx_phase)
         ST_CONNECT: begin
            len = model_cfg.connect_len;
            if (len == 4'd0) len = 4'd1;
            if (len > KEY_LEN_MAX) len = KEY_LEN_MAX;
            if (r.command == CMD_TICK) begin
               if (key_hits >= len) begin
                  rx_phase = ST_AWAIT;
                  ticks_left = model_cfg.start_timeout;
               end else begin
                  ticks_left = ticks_left - 8'd1;
                  if (ticks_left == 8'd0) rx_phase = ST_TIMEOUT;
               end
            end else if (key_hits < len) begin
               want = model_cfg.connect_key[8*int'(key_hits[2:0]) +: 8];
               key_hits = (r.rx_byte == want) ? key_hits + 4'd1 : 4'd0;
            end
         end
         ST_AWAIT: begin
            if (r.command == CMD_TICK) begin
               o.send_valid = 1'b1;
               o.send_byte = BYTE_C;
               ticks_left = ticks_left - 8'd1;
               if (ticks_left == 8'd0) rx_phase = ST_TIMEOUT;
            end else if (r.rx_byte == BYTE_SOH) begin
               rx_phase = ST_RECEIVE;
               frame_pos = 1;
               next_block = 8'd1;
               nak_run = '0;
               load_addr = '0;
               frame_check = '0;
            end
         end
         ST_RECEIVE: begin
            if (r.command == CMD_BYTE) begin
               if (frame_pos == 0) begin
                  if (r.rx_byte == BYTE_EOT) begin
                     o.send_valid = 1'b1;
                     o.send_byte = BYTE_ACK;
                     rx_phase = (nak_run != 3'd0) ? ST_FAILED : ST_DONE;
                  end else begin
                     frame_pos = 1;
                  end
               end else if (frame_pos == 1) begin
                  rcv_block = r.rx_byte;
                  frame_check = '0;
                  frame_pos = 2;
               end else if (frame_pos == 2) begin
                  rcv_compl = r.rx_byte;
                  frame_pos = 3;
               end else if (frame_pos < 3 + FRAME_BYTES) begin
                  o.data_valid = 1'b1;
                  o.data_byte = r.rx_byte;
                  o.data_offset = 7'(frame_pos - 3);
                  frame_check = check_next(frame_check, r.rx_byte, model_cfg.check_mode);
                  frame_pos++;
               end else if (frame_pos == 3 + FRAME_BYTES) begin
                  check_msb = r.rx_byte;
                  frame_pos++;
               end else begin
                  good = (rcv_block == next_block) && (8'(~rcv_compl) == next_block)
                     && (check_msb == frame_check[15:8]) && (r.rx_byte == frame_check[7:0]);
                  frame_pos = 0;
                  o.send_valid = 1'b1;
                  if (good) begin
                     o.send_byte = BYTE_ACK;
                     if (model_cfg.write_limit == '0 || load_addr < model_cfg.write_limit) begin
                        o.commit = 1'b1;
                        o.commit_address = 24'(load_addr);
                        load_addr = load_addr + ADDRESS_BITS'(FRAME_BYTES);
                     end
                     nak_run = '0;
                     next_block = next_block + 8'd1;
                  end else begin
                     o.send_byte = BYTE_NAK;
                     nak_run = nak_run + 3'd1;
                     if (nak_run > MAX_ERRORS) begin
                        rx_phase = ST_FAILED;
                        aborted = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (o.send_valid || o.data_valid || o.commit || rx_phase != prior) begin
         o.status = rx_phase;
         o.last = !aborted;
         rsp_due.push_back(o);
      end
      if (aborted) begin
         o = '0;
         o.send_valid = 1'b1;
         o.send_byte = BYTE_ACK;
         o.status = rx_phase;
         o.last = 1'b1;
         rsp_due.push_back(o);
      end
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] seen,
                                input logic [31:0] wanted);
      $display("%0t mismatch %s: got %0h expected %0h", $time, field, seen, wanted);
      fail_count++;
   endtask

   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      if (rsp_due.size() == 0) begin
         note_mismatch("result with nothing due, status", 32'(got.status), 32'h0);
         return;
      end
      want = rsp_due.pop_front();
      if (got.send_valid !== want.send_valid)
         note_mismatch("send_valid", 32'(got.send_valid), 32'(want.send_valid));
      if (got.send_byte !== want.send_byte)
         note_mismatch("send_byte", 32'(got.send_byte), 32'(want.send_byte));
      if (got.data_valid !== want.data_valid)
         note_mismatch("data_valid", 32'(got.data_valid), 32'(want.data_valid));
      if (got.data_byte !== want.data_byte)
         note_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      if (got.data_offset !== want.data_offset)
         note_mismatch("data_offset", 32'(got.data_offset), 32'(want.data_offset));
      if (got.commit !== want.commit)
         note_mismatch("commit", 32'(got.commit), 32'(want.commit));
      if (got.commit_address !== want.commit_address)
         note_mismatch("commit_address", 32'(got.commit_address),
                       32'(want.commit_address));
      if (got.status !== want.status)
         note_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.last !== want.last)
         note_mismatch("last", 32'(got.last), 32'(want.last));
   endtask

   // predict on every transfer, then check results in order
   always @(posedge clock) begin
      if (reset) begin
         model_cfg = '0;
         model_cfg.connect_len = 4'd1;
         model_cfg.connect_timeout = TIMEOUT_RESET;
         model_cfg.start_timeout = TIMEOUT_RESET;
         rx_phase = ST_CONNECT;
         ticks_left = TIMEOUT_RESET;
         key_hits = '0;
         next_block = 8'd1;
         frame_pos = 0;
         rcv_block = '0;
         rcv_compl = '0;
         frame_check = '0;
         check_msb = '0;
         nak_run = '0;
         load_addr = '0;
         items_taken = 0;
         rsp_due.delete();
      end else begin
         if (csr_valid && csr_ready) load_csr(csr_index, csr_data);
         if (req_valid && req_ready) begin
            advance_receiver(req_data);
            items_taken++;
         end
         if (rsp_valid && rsp_ready) check_rsp(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= req_gap_pct) begin
            req_valid <= 1'b1;
            req_data <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // hold off once for a long stretch so the block fills and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_off <= 0;
         results_taken <= 0;
      end else begin
         if (rsp_valid && rsp_ready) results_taken <= results_taken + 1;
         if (hold_off != 0) begin
            rsp_ready <= 1'b0;
            hold_off <= hold_off - 1;
         end else if (rsp_valid && rsp_ready && results_taken == PRESSURE_AT) begin
            rsp_ready <= 1'b0;
            hold_off <= PRESSURE_CYCLES;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_gap_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_xmodem_crc_receiver failed");
         $finish;
      end
   end

   task automatic push_item(input logic cmd, input logic [7:0] b);
      req_type it;
      it.command = cmd;
      it.rx_byte = b;
      req_backlog.push_back(it);
      items_queued++;
      if (cmd == CMD_BYTE) fed_bytes++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      while (items_taken != items_queued || rsp_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic flaw_type pick_flaw();
      int r;
      r = $urandom_range(0, 99);
      if (tx_nak_run >= 3 || r < 76) return FLAW_NONE;
      if (r < 84) return FLAW_BLOCK;
      if (r < 92) return FLAW_COMPL;
      return FLAW_CHECK;
   endfunction

   task automatic queue_frame(input logic with_lead, input flaw_type flaw);
      logic [7:0]  lead;
      logic [7:0]  blk;
      logic [7:0]  cpl;
      logic [7:0]  b;
      logic [15:0] acc;
      if (with_lead) begin
         lead = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : BYTE_SOH;
         if (lead == BYTE_EOT) lead = BYTE_SOH;
         push_item(CMD_BYTE, lead);
      end
      blk = tx_block;
      if (flaw == FLAW_BLOCK)
         blk = $urandom_range(0, 1) ? tx_block - 8'd1 : tx_block ^ 8'($urandom_range(1, 255));
      cpl = ~blk;
      if (flaw == FLAW_COMPL) cpl = cpl ^ 8'($urandom_range(1, 255));
      push_item(CMD_BYTE, blk);
      push_item(CMD_BYTE, cpl);
      acc = '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         case ($urandom_range(0, 9))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 49) == 0) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
         acc = check_next(acc, b, tx_mode);
         push_item(CMD_BYTE, b);
      end
      if (flaw == FLAW_CHECK) acc = acc ^ (16'h0001 << $urandom_range(0, 15));
      push_item(CMD_BYTE, acc[15:8]);
      push_item(CMD_BYTE, acc[7:0]);
      if (flaw == FLAW_NONE) begin
         tx_block = tx_block + 8'd1;
         tx_nak_run = 0;
      end else begin
         tx_nak_run++;
      end
   endtask

   initial begin
      logic [63:0] gate_key;
      close_type   closing;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gate_key = {$urandom, $urandom};
      gate_key[23:16] = gate_key[7:0] ^ 8'h80;
      write_csr(CSR_KEY, gate_key);
      write_csr(CSR_LEN, 64'd15);
      write_csr(CSR_CONN_TMO, 64'd1);
      write_csr(CSR_START_TMO, 64'd255);
      write_csr(CSR_LIMIT, 64'd0);
      write_csr(CSR_MODE, 64'd0);
      write_csr(CSR_CONN_TMO, 64'd255);

      // partial key, then a byte that breaks it and must not restart the match
      push_item(CMD_BYTE, gate_key[7:0]);
      push_item(CMD_BYTE, gate_key[15:8]);
      push_item(CMD_BYTE, gate_key[7:0]);
      push_item(CMD_TICK, 8'h00);
      for (int k = 0; k < 3; k++) push_item(CMD_BYTE, gate_key[8*k +: 8]);
      settle();
      write_csr(CSR_LEN, 64'd0);

      push_item(CMD_BYTE, 8'hFF);
      push_item(CMD_TICK, 8'hFF);
      push_item(CMD_TICK, 8'h00);
      push_item(CMD_BYTE, BYTE_C);
      push_item(CMD_BYTE, BYTE_EOT);
      push_item(CMD_BYTE, 8'h00);
      push_item(CMD_TICK, 8'h5A);
      push_item(CMD_BYTE, 8'hFF);
      push_item(CMD_TICK, 8'hA5);
      push_item(CMD_BYTE, BYTE_SOH);

      queue_frame(1'b0, FLAW_NONE);
      while (fed_bytes < 560) queue_frame(1'b1, pick_flaw());
      settle();

      req_gap_pct <= 79;
      rsp_gap_pct <= 14;
      write_csr(CSR_KEY, {64{1'b1}});
      write_csr(CSR_LEN, 64'd1);
      write_csr(CSR_START_TMO, 64'd1);
      write_csr(CSR_LIMIT, 64'h300);
      write_csr(CSR_MODE, 64'd1);
      tx_mode = 1'b1;
      while (fed_bytes < 1110) queue_frame(1'b1, pick_flaw());
      settle();

      req_gap_pct <= 0;
      rsp_gap_pct <= 0;
      write_csr(CSR_KEY, 64'd0);
      write_csr(CSR_LEN, 64'd8);
      write_csr(CSR_LIMIT, 64'hFF_FFFF);
      write_csr(CSR_MODE, 64'd0);
      tx_mode = 1'b0;
      while (fed_bytes < 1650) queue_frame(1'b1, pick_flaw());

      closing = close_type'($urandom_range(0, 2));
      case (closing)
         CLOSE_CLEAN: begin
            if (tx_nak_run != 0) queue_frame(1'b1, FLAW_NONE);
            push_item(CMD_BYTE, BYTE_EOT);
         end
         CLOSE_AFTER_NAK: begin
            if (tx_nak_run == 0) queue_frame(1'b1, flaw_type'($urandom_range(1, 3)));
            push_item(CMD_BYTE, BYTE_EOT);
         end
         default: begin
            while (tx_nak_run < 4) queue_frame(1'b1, flaw_type'($urandom_range(1, 3)));
         end
      endcase
      // drop: everything after the final phase is ignored
      push_item(CMD_TICK, 8'h00);
      push_item(CMD_BYTE, BYTE_SOH);
      push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      settle();

      if (fail_count == 0)
         $display("tb_xmodem_crc_receiver passed");
      else
         $display("tb_xmodem_crc_receiver failed");
      $finish;
   end

endmodule

// ----- files.f -----
sv/xcr_pkg.sv
sv/xcr_check.sv
sv/xcr_fifo.sv
sv/xcr_core.sv
sv/xmodem_crc_receiver.sv
verif/tb_xmodem_crc_receiver.sv
